FILE: rtl/core/string_insertion_sort_top_macros.svh
// ----------------------------------------------------------------------------
// String insertion sort assertion macros
// Shared helpers for the concurrent checks of the sort block.
// ----------------------------------------------------------------------------
`ifndef STRING_INSERTION_SORT_TOP_MACROS_SVH
`define STRING_INSERTION_SORT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and off during reset.
`define SIS_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk_i and off during reset.
`define SIS_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) else $error(msg);

`endif

FILE: rtl/core/sis_pkg.sv
// ----------------------------------------------------------------------------
// String insertion sort package
// Shared constants, controller opcodes and the status bundle.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int SIS_MAX_STRINGS = 64;
  localparam int SIS_MAX_LENGTH  = 32;

  typedef logic [4:0] sis_op_t;

  localparam sis_op_t OP_NONE      = 5'd0;
  localparam sis_op_t OP_LOAD      = 5'd1;
  localparam sis_op_t OP_INIT      = 5'd2;
  localparam sis_op_t OP_SETI1     = 5'd3;
  localparam sis_op_t OP_KEY_RD    = 5'd4;
  localparam sis_op_t OP_KEY_LEN   = 5'd5;
  localparam sis_op_t OP_KEY_CAP   = 5'd6;
  localparam sis_op_t OP_PREV_RD   = 5'd7;
  localparam sis_op_t OP_PREV_LEN  = 5'd8;
  localparam sis_op_t OP_PREV_CAP  = 5'd9;
  localparam sis_op_t OP_RDA       = 5'd10;
  localparam sis_op_t OP_RDB       = 5'd11;
  localparam sis_op_t OP_NEXTK     = 5'd12;
  localparam sis_op_t OP_SHIFT     = 5'd13;
  localparam sis_op_t OP_PLACE_KEY = 5'd14;
  localparam sis_op_t OP_FINISH    = 5'd15;
  localparam sis_op_t OP_F_ORD     = 5'd16;
  localparam sis_op_t OP_F_LEN     = 5'd17;
  localparam sis_op_t OP_F_CH      = 5'd18;
  localparam sis_op_t OP_F_OUT     = 5'd19;

  typedef struct packed {
    logic i_done;
    logic j_zero;
    logic k_end;
    logic len_after;
    logic cmp_neq;
    logic cmp_gt;
    logic out_free;
  } sis_status_t;

endpackage

FILE: rtl/core/string_insertion_sort_top.sv
// ----------------------------------------------------------------------------
// String insertion sort
// Loads short byte strings, sorts them stably in byte order, streams them out.
// ----------------------------------------------------------------------------
// Usage: the slave channel carries load and fetch beats, told apart by tuser.
// A load beat appends one byte (zero means no byte) to the current string;
// the string-end flag in tdata closes the string and tlast closes the whole
// set. After a tlast load the block drops s_axis_tready and runs an insertion
// sort; each comparison reads both strings one byte at a time, going through
// the compare, read and check states for every byte, and spends further
// states on setup and decision.
// A fetch beat reads the order table, then the length table, then the byte
// store, one memory read a cycle, and drops its result into the output
// register. The result waits there while the receiver stalls, and a load may
// be taken meanwhile; the next fetch holds in its last step until the output
// register frees up. A fetch before a sort, or past the end, returns a beat
// with the exhausted flag set. The first load after a sort starts a new set.
// Reset clears the counters, the overflow flag and the output valid; the
// stores are not cleared, as every read whose data is used hits an entry
// written in the same set.
// ----------------------------------------------------------------------------
`include "string_insertion_sort_top_macros.svh"

module string_insertion_sort_top import sis_pkg::*; #(
  parameter int MAX_STRINGS = SIS_MAX_STRINGS,
  parameter int MAX_LENGTH  = SIS_MAX_LENGTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] in_char, [8] string_end, zero fill
  input  logic        s_axis_tuser_i,   // [0] req_type
  input  logic        s_axis_tlast_i,   // set_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_char, [8] out_string_end, zero fill
  output logic [1:0]  m_axis_tuser_o,   // [0] out_exhausted, [1] overflow
  output logic        m_axis_tlast_o    // out_set_end
);

  sis_op_t     op;
  sis_status_t status;
  logic        in_ready;
  logic [7:0]  out_char;
  logic        out_str_end, out_set_end, out_exh, out_ovf;

  sis_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i   (s_axis_tvalid_i),
    .in_req_i     (s_axis_tuser_i),
    .in_set_end_i (s_axis_tlast_i),
    .status_i     (status),
    .in_ready_o   (in_ready),
    .op_o         (op)
  );

  sis_dp #(
    .MAX_STRINGS (MAX_STRINGS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .op_i          (op),
    .in_char_i     (s_axis_tdata_i[7:0]),
    .in_str_end_i  (s_axis_tdata_i[8]),
    .in_set_end_i  (s_axis_tlast_i),
    .m_tready_i    (m_axis_tready_i),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid_o),
    .out_char_o    (out_char),
    .out_str_end_o (out_str_end),
    .out_set_end_o (out_set_end),
    .out_exh_o     (out_exh),
    .out_ovf_o     (out_ovf)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tdata_o  = {7'd0, out_str_end, out_char};
  assign m_axis_tuser_o  = {out_ovf, out_exh};
  assign m_axis_tlast_o  = out_set_end;

  // An exhausted beat carries no byte and no end marks.
  `SIS_ASSERT_NOW(a_exh_empty, m_axis_tvalid_o && out_exh, (out_char == 8'd0) && !out_str_end && !out_set_end, "exhausted beat carries data")
  // The end of the set is always the end of a string.
  `SIS_ASSERT_NOW(a_set_end_str, m_axis_tvalid_o && out_set_end, out_str_end, "set end without string end")
  // Closing a set starts the sort, which holds off the input.
  `SIS_ASSERT_NEXT(a_sort_stall, s_axis_tvalid_i && in_ready && !s_axis_tuser_i && s_axis_tlast_i, !in_ready, "input taken during sort")

endmodule

FILE: rtl/core/sis_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module sis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sis_dp.sv
// ----------------------------------------------------------------------------
// String insertion sort datapath
// Byte, length and order stores, counters, comparator and output register.
// ----------------------------------------------------------------------------
module sis_dp import sis_pkg::*; #(
  parameter int MAX_STRINGS = SIS_MAX_STRINGS,
  parameter int MAX_LENGTH  = SIS_MAX_LENGTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sis_op_t     op_i,
  input  logic [7:0]  in_char_i,
  input  logic        in_str_end_i,
  input  logic        in_set_end_i,
  input  logic        m_tready_i,
  output sis_status_t status_o,
  output logic        out_valid_o,
  output logic [7:0]  out_char_o,
  output logic        out_str_end_o,
  output logic        out_set_end_o,
  output logic        out_exh_o,
  output logic        out_ovf_o
);

  localparam int SW  = $clog2(MAX_STRINGS);
  localparam int CW  = $clog2(MAX_STRINGS + 1);
  localparam int PW  = $clog2(MAX_LENGTH + 1);
  localparam int AP  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CAW = SW + AP;
  localparam int CD  = MAX_STRINGS * (2 ** AP);
  localparam logic [CW-1:0] MS_C = CW'(MAX_STRINGS);
  localparam logic [PW-1:0] ML_C = PW'(MAX_LENGTH);

  logic [CW-1:0] str_cnt_q, rd_str_q, i_q, j_q;
  logic [PW-1:0] load_pos_q, rd_pos_q, k_q;
  logic          ovf_q, done_q, out_valid_q;
  logic [SW-1:0] key_q, prev_q, idx_q;
  logic [PW-1:0] keylen_q, plen_q, len_q;
  logic [7:0]    ca_q, out_char_q;
  logic          out_str_end_q, out_set_end_q, out_exh_q, out_ovf_q;

  logic           ch_we, ch_re, ln_we, ln_re, od_we, od_re;
  logic [CAW-1:0] ch_waddr, ch_raddr;
  logic [7:0]     ch_wdata, ch_rdata;
  logic [SW-1:0]  ln_waddr, ln_raddr, od_waddr, od_raddr, od_wdata, od_rdata;
  logic [PW-1:0]  ln_wdata, ln_rdata;

  // Load bookkeeping; a sorted set is discarded by the first new load.
  logic [CW-1:0] base_cnt, jm1;
  logic [PW-1:0] base_pos, pos_next;
  logic          byte_in, byte_ok, ends, cnt_ok, drop;

  assign base_cnt = done_q ? '0 : str_cnt_q;
  assign base_pos = done_q ? '0 : load_pos_q;
  assign byte_in  = (in_char_i != 8'd0);
  assign byte_ok  = (base_cnt < MS_C) && (base_pos < ML_C);
  assign pos_next = (byte_in && byte_ok) ? base_pos + PW'(1) : base_pos;
  assign ends     = in_str_end_i || in_set_end_i;
  assign cnt_ok   = (base_cnt < MS_C);
  assign drop     = (byte_in && !byte_ok) || (ends && !cnt_ok);
  assign jm1      = j_q - CW'(1);

  // Fetch result
  logic avail, len0, last;
  assign avail = done_q && (rd_str_q < str_cnt_q);
  assign len0  = (len_q == '0);
  assign last  = len0 || (PW'(rd_pos_q + PW'(1)) >= len_q);

  always_comb begin
    ch_we = 1'b0; ch_waddr = '0; ch_wdata = in_char_i; ch_re = 1'b0; ch_raddr = '0;
    ln_we = 1'b0; ln_waddr = '0; ln_wdata = pos_next;  ln_re = 1'b0; ln_raddr = '0;
    od_we = 1'b0; od_waddr = '0; od_wdata = '0;        od_re = 1'b0; od_raddr = '0;
    case (op_i)
      OP_LOAD: begin
        ch_we    = byte_in && byte_ok;
        ch_waddr = {base_cnt[SW-1:0], base_pos[AP-1:0]};
        ln_we    = ends && cnt_ok;
        ln_waddr = base_cnt[SW-1:0];
      end
      OP_INIT: begin
        od_we    = 1'b1;
        od_waddr = i_q[SW-1:0];
        od_wdata = i_q[SW-1:0];
      end
      OP_KEY_RD: begin
        od_re    = 1'b1;
        od_raddr = i_q[SW-1:0];
      end
      OP_KEY_LEN, OP_PREV_LEN, OP_F_LEN: begin
        ln_re    = 1'b1;
        ln_raddr = od_rdata;
      end
      OP_PREV_RD: begin
        od_re    = 1'b1;
        od_raddr = jm1[SW-1:0];
      end
      OP_RDA: begin
        ch_re    = 1'b1;
        ch_raddr = {prev_q, k_q[AP-1:0]};
      end
      OP_RDB: begin
        ch_re    = 1'b1;
        ch_raddr = {key_q, k_q[AP-1:0]};
      end
      OP_SHIFT: begin
        od_we    = 1'b1;
        od_waddr = j_q[SW-1:0];
        od_wdata = prev_q;
      end
      OP_PLACE_KEY: begin
        od_we    = 1'b1;
        od_waddr = j_q[SW-1:0];
        od_wdata = key_q;
      end
      OP_F_ORD: begin
        od_re    = 1'b1;
        od_raddr = rd_str_q[SW-1:0];
      end
      OP_F_CH: begin
        ch_re    = 1'b1;
        ch_raddr = {idx_q, rd_pos_q[AP-1:0]};
      end
      default: begin
      end
    endcase
  end

  sis_ram #(.WIDTH(8), .DEPTH(CD)) u_char_ram (
    .clk_i, .we_i(ch_we), .waddr_i(ch_waddr), .wdata_i(ch_wdata),
    .re_i(ch_re), .raddr_i(ch_raddr), .rdata_o(ch_rdata)
  );

  sis_ram #(.WIDTH(PW), .DEPTH(MAX_STRINGS)) u_len_ram (
    .clk_i, .we_i(ln_we), .waddr_i(ln_waddr), .wdata_i(ln_wdata),
    .re_i(ln_re), .raddr_i(ln_raddr), .rdata_o(ln_rdata)
  );

  sis_ram #(.WIDTH(SW), .DEPTH(MAX_STRINGS)) u_order_ram (
    .clk_i, .we_i(od_we), .waddr_i(od_waddr), .wdata_i(od_wdata),
    .re_i(od_re), .raddr_i(od_raddr), .rdata_o(od_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_cnt_q   <= '0;
      load_pos_q  <= '0;
      rd_str_q    <= '0;
      rd_pos_q    <= '0;
      ovf_q       <= 1'b0;
      done_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_F_OUT) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        OP_LOAD: begin
          str_cnt_q  <= (ends && cnt_ok) ? base_cnt + CW'(1) : base_cnt;
          load_pos_q <= ends ? '0 : pos_next;
          ovf_q      <= ovf_q || drop;
          done_q     <= 1'b0;
          i_q        <= '0;
        end
        OP_INIT, OP_PLACE_KEY: i_q <= i_q + CW'(1);
        OP_SETI1:    i_q <= CW'(1);
        OP_KEY_LEN:  j_q <= i_q;
        OP_PREV_CAP: k_q <= '0;
        OP_NEXTK:    k_q <= k_q + PW'(1);
        OP_SHIFT:    j_q <= jm1;
        OP_FINISH: begin
          done_q   <= 1'b1;
          rd_str_q <= '0;
          rd_pos_q <= '0;
        end
        OP_F_OUT: begin
          if (avail) begin
            if (last) begin
              rd_str_q <= rd_str_q + CW'(1);
              rd_pos_q <= '0;
            end else begin
              rd_pos_q <= rd_pos_q + PW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_KEY_LEN:  key_q    <= od_rdata;
      OP_KEY_CAP:  keylen_q <= ln_rdata;
      OP_PREV_LEN: prev_q   <= od_rdata;
      OP_PREV_CAP: plen_q   <= ln_rdata;
      OP_RDB:      ca_q     <= ch_rdata;
      OP_F_LEN:    idx_q    <= od_rdata;
      OP_F_CH:     len_q    <= ln_rdata;
      OP_F_OUT: begin
        out_char_q    <= (avail && !len0) ? ch_rdata : 8'd0;
        out_str_end_q <= avail && last;
        out_set_end_q <= avail && last && (CW'(rd_str_q + CW'(1)) == str_cnt_q);
        out_exh_q     <= !avail;
        out_ovf_q     <= ovf_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.i_done    = (i_q >= str_cnt_q);
  assign status_o.j_zero    = (j_q == '0);
  assign status_o.k_end     = (k_q >= plen_q) || (k_q >= keylen_q);
  assign status_o.len_after = (plen_q > keylen_q);
  assign status_o.cmp_neq   = (ca_q != ch_rdata);
  assign status_o.cmp_gt    = (ca_q > ch_rdata);
  assign status_o.out_free  = !out_valid_q || m_tready_i;

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign out_str_end_o = out_str_end_q;
  assign out_set_end_o = out_set_end_q;
  assign out_exh_o     = out_exh_q;
  assign out_ovf_o     = out_ovf_q;

endmodule

FILE: rtl/core/sis_ctrl.sv
// ----------------------------------------------------------------------------
// String insertion sort controller
// Sequences loads, the insertion sort passes and the fetch reads.
// ----------------------------------------------------------------------------
module sis_ctrl import sis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_req_i,
  input  logic        in_set_end_i,
  input  sis_status_t status_i,
  output logic        in_ready_o,
  output sis_op_t     op_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_OUTER = 4'd2;
  localparam logic [3:0] S_KLEN  = 4'd3;
  localparam logic [3:0] S_KCAP  = 4'd4;
  localparam logic [3:0] S_INNER = 4'd5;
  localparam logic [3:0] S_PLEN  = 4'd6;
  localparam logic [3:0] S_PCAP  = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_RDB   = 4'd9;
  localparam logic [3:0] S_CHK   = 4'd10;
  localparam logic [3:0] S_FA    = 4'd11;
  localparam logic [3:0] S_FB    = 4'd12;
  localparam logic [3:0] S_FC    = 4'd13;
  localparam logic [3:0] S_FD    = 4'd14;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i) begin
            state_d = S_FA;
          end else begin
            op_o    = OP_LOAD;
            state_d = in_set_end_i ? S_INIT : S_IDLE;
          end
        end
      end
      S_INIT: begin
        if (status_i.i_done) begin
          op_o    = OP_SETI1;
          state_d = S_OUTER;
        end else begin
          op_o = OP_INIT;
        end
      end
      S_OUTER: begin
        if (status_i.i_done) begin
          op_o    = OP_FINISH;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_KEY_RD;
          state_d = S_KLEN;
        end
      end
      S_KLEN: begin
        op_o    = OP_KEY_LEN;
        state_d = S_KCAP;
      end
      S_KCAP: begin
        op_o    = OP_KEY_CAP;
        state_d = S_INNER;
      end
      S_INNER: begin
        if (status_i.j_zero) begin
          op_o    = OP_PLACE_KEY;
          state_d = S_OUTER;
        end else begin
          op_o    = OP_PREV_RD;
          state_d = S_PLEN;
        end
      end
      S_PLEN: begin
        op_o    = OP_PREV_LEN;
        state_d = S_PCAP;
      end
      S_PCAP: begin
        op_o    = OP_PREV_CAP;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!status_i.k_end) begin
          op_o    = OP_RDA;
          state_d = S_RDB;
        end else if (status_i.len_after) begin
          op_o    = OP_SHIFT;
          state_d = S_INNER;
        end else begin
          op_o    = OP_PLACE_KEY;
          state_d = S_OUTER;
        end
      end
      S_RDB: begin
        op_o    = OP_RDB;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!status_i.cmp_neq) begin
          op_o    = OP_NEXTK;
          state_d = S_CMP;
        end else if (status_i.cmp_gt) begin
          op_o    = OP_SHIFT;
          state_d = S_INNER;
        end else begin
          op_o    = OP_PLACE_KEY;
          state_d = S_OUTER;
        end
      end
      S_FA: begin
        op_o    = OP_F_ORD;
        state_d = S_FB;
      end
      S_FB: begin
        op_o    = OP_F_LEN;
        state_d = S_FC;
      end
      S_FC: begin
        op_o    = OP_F_CH;
        state_d = S_FD;
      end
      S_FD: begin
        if (status_i.out_free) begin
          op_o    = OP_F_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
